// ===== rtl/core/sprt_pkg.sv =====
package sprt_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_OUT_W = 40;
   localparam int STATUS_W   = 3;
   localparam int REQ_KIND_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_MISALIGNED = 3'd1,
      ST_CONFLICT   = 3'd2,
      ST_FULL       = 3'd3,
      ST_NOT_FOUND  = 3'd4,
      ST_UNKNOWN    = 3'd5
   } status_type;

   typedef enum logic [REQ_KIND_W-1:0] {
      REQ_MAP       = 2'd0,
      REQ_UNMAP     = 2'd1,
      REQ_VIOLATION = 2'd2,
      REQ_NONE      = 2'd3
   } req_kind_type;

   // result of comparing one table entry against the pending item
   typedef struct packed {
      logic guest_hit;
      logic conflict;
   } match_type;

endpackage

// ===== rtl/core/sprt_cmp_unit.sv =====
module sprt_cmp_unit #(
   parameter int PAGE_W = 40
) (
   input  logic [PAGE_W-1:0]  ent_guest_page,
   input  logic [PAGE_W-1:0]  ent_rw_page,
   input  logic [PAGE_W-1:0]  ent_fetch_page,
   input  logic [PAGE_W-1:0]  new_guest_page,
   input  logic [PAGE_W-1:0]  new_rw_page,
   input  logic [PAGE_W-1:0]  new_fetch_page,
   output sprt_pkg::match_type match
);
   import sprt_pkg::*;

   logic guest_eq;

   assign guest_eq = (ent_guest_page == new_guest_page);

   assign match.guest_hit = guest_eq;
   // either mapping's guest page equal to any of the other mapping's pages
   assign match.conflict  = guest_eq
                          || (ent_fetch_page == new_guest_page)
                          || (ent_rw_page == new_guest_page)
                          || (ent_guest_page == new_rw_page)
                          || (ent_guest_page == new_fetch_page);

endmodule

// ===== rtl/core/split_page_remap_table_core.sv =====
// Timing: a misaligned map, an unmap with a page offset or an unused request code
// answers in the cycle after accept; other items scan the table one entry per cycle,
// stopping early when a lookup or unmap hits or a map clashes.
// Throughput: one item at a time; a new item is taken the cycle after the result leaves.
// Reset (synchronous, active high) clears all entry valid bits and the sequencer;
// entry pages stay unwritten until a map stores them.
module split_page_remap_table_core #(
   parameter int MAX_ENTRIES = 16,
   parameter int ADDR_BITS   = 52
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sprt_pkg::REQ_KIND_W-1:0] req_type,
   input  logic [ADDR_BITS-1:0]            req_guest_addr,
   input  logic [ADDR_BITS-1:0]            req_host_rw_addr,
   input  logic [ADDR_BITS-1:0]            req_host_fetch_addr,
   input  logic                            req_access_read,
   input  logic                            req_access_write,
   input  logic                            req_access_fetch,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sprt_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_remap_valid,
   output logic [sprt_pkg::PAGE_OUT_W-1:0] rsp_remap_guest_page,
   output logic [sprt_pkg::PAGE_OUT_W-1:0] rsp_remap_target_page,
   output logic                            rsp_remap_allow_rw,
   output logic                            rsp_remap_allow_fetch,
   output logic                            rsp_flush_translations
);
   import sprt_pkg::*;

   localparam int PAGE_W = ADDR_BITS - PAGE_SHIFT;
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
   localparam logic [CNT_W-1:0] NUM_ENT  = CNT_W'(MAX_ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // pending item
   req_kind_type      kind_ff, kind_in;
   logic [PAGE_W-1:0] gp_ff, gp_in;
   logic [PAGE_W-1:0] rp_ff, rp_in;
   logic [PAGE_W-1:0] fp_ff, fp_in;
   logic              acc_rw_ff, acc_rw_in;
   logic              acc_fetch_ff, acc_fetch_in;

   // scan sequencer
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   // table
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [3*PAGE_W-1:0]    mem [MAX_ENTRIES];
   logic [3*PAGE_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;

   logic [PAGE_W-1:0] ent_guest;
   logic [PAGE_W-1:0] ent_rw;
   logic [PAGE_W-1:0] ent_fetch;
   match_type         match;

   // result register
   status_type        status_ff, status_in;
   logic              cmd_ff, cmd_in;
   logic [PAGE_W-1:0] out_guest_ff, out_guest_in;
   logic [PAGE_W-1:0] out_target_ff, out_target_in;
   logic              out_rw_ff, out_rw_in;
   logic              out_fetch_ff, out_fetch_in;

   logic req_acc;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;

   assign ent_guest = rd_data_ff[3*PAGE_W-1:2*PAGE_W];
   assign ent_rw    = rd_data_ff[2*PAGE_W-1:PAGE_W];
   assign ent_fetch = rd_data_ff[PAGE_W-1:0];

   sprt_cmp_unit #(
      .PAGE_W(PAGE_W)
   ) u_cmp (
      .ent_guest_page (ent_guest),
      .ent_rw_page    (ent_rw),
      .ent_fetch_page (ent_fetch),
      .new_guest_page (gp_ff),
      .new_rw_page    (rp_ff),
      .new_fetch_page (fp_ff),
      .match          (match)
   );

   always_comb begin
      logic        fin;
      logic        ent_vld;
      logic        last;
      logic        g_off;
      logic        r_off;
      logic        f_off;
      fin           = 1'b0;
      ent_vld       = 1'b0;
      last          = 1'b0;
      g_off         = |req_guest_addr[PAGE_SHIFT-1:0];
      r_off         = |req_host_rw_addr[PAGE_SHIFT-1:0];
      f_off         = |req_host_fetch_addr[PAGE_SHIFT-1:0];
      state_in      = state_ff;
      kind_in       = kind_ff;
      gp_in         = gp_ff;
      rp_in         = rp_ff;
      fp_in         = fp_ff;
      acc_rw_in     = acc_rw_ff;
      acc_fetch_in  = acc_fetch_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      rd_addr       = issue_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_idx        = free_idx_ff;
      status_in     = status_ff;
      cmd_in        = cmd_ff;
      out_guest_in  = out_guest_ff;
      out_target_in = out_target_ff;
      out_rw_in     = out_rw_ff;
      out_fetch_in  = out_fetch_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               kind_in       = req_kind_type'(req_type);
               gp_in         = req_guest_addr[ADDR_BITS-1:PAGE_SHIFT];
               rp_in         = req_host_rw_addr[ADDR_BITS-1:PAGE_SHIFT];
               fp_in         = req_host_fetch_addr[ADDR_BITS-1:PAGE_SHIFT];
               acc_rw_in     = req_access_read || req_access_write;
               acc_fetch_in  = req_access_fetch;
               issue_in      = '0;
               free_found_in = 1'b0;
               status_in     = ST_OK;
               cmd_in        = 1'b0;
               out_guest_in  = '0;
               out_target_in = '0;
               out_rw_in     = 1'b0;
               out_fetch_in  = 1'b0;
               unique case (req_kind_type'(req_type))
                  REQ_MAP: begin
                     if (g_off || r_off || f_off) begin
                        status_in = ST_MISALIGNED;
                        fin       = 1'b1;
                     end
                  end
                  REQ_UNMAP: begin
                     // full-address compare: an offset can never match
                     if (g_off) begin
                        status_in = ST_NOT_FOUND;
                        fin       = 1'b1;
                     end
                  end
                  REQ_VIOLATION: begin
                  end
                  REQ_NONE: begin
                     fin = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
               state_in = fin ? S_RESP : S_SCAN;
            end
         end

         S_SCAN: begin
            // read one entry per cycle; it is checked the following cycle
            if (issue_ff < NUM_ENT) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               ent_vld = valid_ff[chk_idx_ff];
               last    = (chk_idx_ff == LAST_IDX);
               unique case (kind_ff)
                  REQ_MAP: begin
                     if (ent_vld && match.conflict) begin
                        status_in = ST_CONFLICT;
                        fin       = 1'b1;
                     end else begin
                        if (!ent_vld && !free_found_ff) begin
                           free_found_in = 1'b1;
                           free_idx_in   = chk_idx_ff;
                        end
                        if (last) begin
                           fin = 1'b1;
                           if (free_found_ff || !ent_vld) begin
                              wr_en            = 1'b1;
                              wr_idx           = free_found_ff ? free_idx_ff : chk_idx_ff;
                              valid_in[wr_idx] = 1'b1;
                              cmd_in           = 1'b1;
                              out_guest_in     = gp_ff;
                              out_target_in    = gp_ff;
                           end else begin
                              status_in = ST_FULL;
                           end
                        end
                     end
                  end
                  REQ_UNMAP: begin
                     if (ent_vld && match.guest_hit) begin
                        fin                  = 1'b1;
                        valid_in[chk_idx_ff] = 1'b0;
                        cmd_in               = 1'b1;
                        out_guest_in         = gp_ff;
                        out_target_in        = gp_ff;
                        out_rw_in            = 1'b1;
                        out_fetch_in         = 1'b1;
                     end else if (last) begin
                        status_in = ST_NOT_FOUND;
                        fin       = 1'b1;
                     end
                  end
                  default: begin
                     if (ent_vld && match.guest_hit) begin
                        fin = 1'b1;
                        // data access takes precedence over fetch
                        if (acc_rw_ff) begin
                           cmd_in        = 1'b1;
                           out_guest_in  = ent_guest;
                           out_target_in = ent_rw;
                           out_rw_in     = 1'b1;
                        end else if (acc_fetch_ff) begin
                           cmd_in        = 1'b1;
                           out_guest_in  = ent_guest;
                           out_target_in = ent_fetch;
                           out_fetch_in  = 1'b1;
                        end else begin
                           status_in = ST_UNKNOWN;
                        end
                     end else if (last) begin
                        status_in = ST_NOT_FOUND;
                        fin       = 1'b1;
                     end
                  end
               endcase
            end
            if (fin) begin
               chk_vld_in = 1'b0;
               state_in   = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      gp_ff         <= gp_in;
      rp_ff         <= rp_in;
      fp_ff         <= fp_in;
      acc_rw_ff     <= acc_rw_in;
      acc_fetch_ff  <= acc_fetch_in;
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      status_ff     <= status_in;
      cmd_ff        <= cmd_in;
      out_guest_ff  <= out_guest_in;
      out_target_ff <= out_target_in;
      out_rw_ff     <= out_rw_in;
      out_fetch_ff  <= out_fetch_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {gp_ff, rp_ff, fp_ff};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid              = (state_ff == S_RESP);
   assign rsp_status             = status_ff;
   assign rsp_remap_valid        = cmd_ff;
   assign rsp_remap_guest_page   = PAGE_OUT_W'(out_guest_ff);
   assign rsp_remap_target_page  = PAGE_OUT_W'(out_target_ff);
   assign rsp_remap_allow_rw     = out_rw_ff;
   assign rsp_remap_allow_fetch  = out_fetch_ff;
   assign rsp_flush_translations = cmd_ff;

endmodule

// ===== sim/remap_table_checker.sv =====
`timescale 1ns / 1ps

module remap_table_checker #(
   parameter int MAX_ENTRIES = 16,
   parameter int ADDR_BITS   = 52
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sprt_pkg::REQ_KIND_W-1:0] req_type,
   input  logic [ADDR_BITS-1:0]            req_guest_addr,
   input  logic [ADDR_BITS-1:0]            req_host_rw_addr,
   input  logic [ADDR_BITS-1:0]            req_host_fetch_addr,
   input  logic                            req_access_read,
   input  logic                            req_access_write,
   input  logic                            req_access_fetch,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sprt_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            rsp_remap_valid,
   input  logic [sprt_pkg::PAGE_OUT_W-1:0] rsp_remap_guest_page,
   input  logic [sprt_pkg::PAGE_OUT_W-1:0] rsp_remap_target_page,
   input  logic                            rsp_remap_allow_rw,
   input  logic                            rsp_remap_allow_fetch,
   input  logic                            rsp_flush_translations,
   output int                              mismatch_count,
   output int                              outstanding,
   output int                              results_checked,
   output int                              remaps_seen,
   output int                              rejects_seen
);

   import sprt_pkg::*;

   typedef struct packed {
      status_type             status;
      logic                   cmd;
      logic [PAGE_OUT_W-1:0]  gpage;
      logic [PAGE_OUT_W-1:0]  tpage;
      logic                   allow_rw;
      logic                   allow_fetch;
      logic                   flush;
   } remap_result_type;

   // shadow copy of the remap table
   logic                  slot_used  [MAX_ENTRIES];
   logic [PAGE_OUT_W-1:0] slot_guest [MAX_ENTRIES];
   logic [PAGE_OUT_W-1:0] slot_rw    [MAX_ENTRIES];
   logic [PAGE_OUT_W-1:0] slot_fetch [MAX_ENTRIES];

   remap_result_type pending_results [$];

   initial begin
      mismatch_count  = 0;
      outstanding     = 0;
      results_checked = 0;
      remaps_seen     = 0;
      rejects_seen    = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic predict_remap(input req_kind_type kind,
                                input logic [ADDR_BITS-1:0] ga,
                                input logic [ADDR_BITS-1:0] ra,
                                input logic [ADDR_BITS-1:0] fa,
                                input logic rd, input logic wr, input logic fe,
                                output remap_result_type res);
      logic [PAGE_OUT_W-1:0] gp;
      logic [PAGE_OUT_W-1:0] rp;
      logic [PAGE_OUT_W-1:0] fp;
      int hit;
      int free_slot;
      bit clash;
      gp = PAGE_OUT_W'(ga >> PAGE_SHIFT);
      rp = PAGE_OUT_W'(ra >> PAGE_SHIFT);
      fp = PAGE_OUT_W'(fa >> PAGE_SHIFT);
      hit = -1;
      free_slot = -1;
      clash = 1'b0;
      res = '0;
      res.status = ST_OK;
      case (kind)
         REQ_MAP: begin
            if (ga[PAGE_SHIFT-1:0] != '0 || ra[PAGE_SHIFT-1:0] != '0 ||
                fa[PAGE_SHIFT-1:0] != '0) begin
               res.status = ST_MISALIGNED;
            end else begin
               for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
                  if (slot_used[i] &&
                      (slot_guest[i] == gp || slot_rw[i] == gp || slot_fetch[i] == gp ||
                       slot_guest[i] == rp || slot_guest[i] == fp))
                     clash = 1'b1;
                  if (!slot_used[i])
                     free_slot = i;
               end
               if (clash) begin
                  res.status = ST_CONFLICT;
               end else if (free_slot < 0) begin
                  res.status = ST_FULL;
               end else begin
                  slot_used[free_slot]  = 1'b1;
                  slot_guest[free_slot] = gp;
                  slot_rw[free_slot]    = rp;
                  slot_fetch[free_slot] = fp;
                  // guest page loses all access until a violation remaps it
                  res.cmd   = 1'b1;
                  res.gpage = gp;
                  res.tpage = gp;
                  res.flush = 1'b1;
               end
            end
         end
         REQ_UNMAP: begin
            // full address compare: any page offset misses
            if (ga[PAGE_SHIFT-1:0] == '0)
               for (int i = MAX_ENTRIES - 1; i >= 0; i--)
                  if (slot_used[i] && slot_guest[i] == gp)
                     hit = i;
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               slot_used[hit]   = 1'b0;
               res.cmd         = 1'b1;
               res.gpage       = gp;
               res.tpage       = gp;
               res.allow_rw    = 1'b1;
               res.allow_fetch = 1'b1;
               res.flush       = 1'b1;
            end
         end
         REQ_VIOLATION: begin
            for (int i = MAX_ENTRIES - 1; i >= 0; i--)
               if (slot_used[i] && slot_guest[i] == gp)
                  hit = i;
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else if (rd || wr) begin
               res.cmd      = 1'b1;
               res.gpage    = slot_guest[hit];
               res.tpage    = slot_rw[hit];
               res.allow_rw = 1'b1;
               res.flush    = 1'b1;
            end else if (fe) begin
               res.cmd         = 1'b1;
               res.gpage       = slot_guest[hit];
               res.tpage       = slot_fetch[hit];
               res.allow_fetch = 1'b1;
               res.flush       = 1'b1;
            end else begin
               res.status = ST_UNKNOWN;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      remap_result_type want;
      remap_result_type fresh;
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++)
            slot_used[i] = 1'b0;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_status, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_remap_valid !== want.cmd)
                  report_mismatch("remap_valid", rsp_remap_valid, want.cmd);
               if (rsp_remap_guest_page !== want.gpage)
                  report_mismatch("remap_guest_page", rsp_remap_guest_page, want.gpage);
               if (rsp_remap_target_page !== want.tpage)
                  report_mismatch("remap_target_page", rsp_remap_target_page, want.tpage);
               if (rsp_remap_allow_rw !== want.allow_rw)
                  report_mismatch("remap_allow_rw", rsp_remap_allow_rw, want.allow_rw);
               if (rsp_remap_allow_fetch !== want.allow_fetch)
                  report_mismatch("remap_allow_fetch", rsp_remap_allow_fetch,
                                  want.allow_fetch);
               if (rsp_flush_translations !== want.flush)
                  report_mismatch("flush_translations", rsp_flush_translations, want.flush);
               if (want.cmd)
                  remaps_seen++;
               if (want.status != ST_OK)
                  rejects_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            predict_remap(req_kind_type'(req_type), req_guest_addr, req_host_rw_addr,
                          req_host_fetch_addr, req_access_read, req_access_write,
                          req_access_fetch, fresh);
            pending_results.push_back(fresh);
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// ===== sim/split_page_remap_table_core_test.sv =====
`timescale 1ns / 1ps

module split_page_remap_table_core_test;

   import sprt_pkg::*;

   localparam int MAX_ENTRIES  = 16;
   localparam int ADDR_BITS    = 52;
   localparam int RANDOM_ITEMS = 1050;
   localparam int GUEST_POOL   = 20;
   localparam int HOST_POOL    = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [PAGE_OUT_W-1:0] TOP_PAGE = '1;

   logic                   clock;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_stall;
   logic [REQ_KIND_W-1:0]  req_type            = '0;
   logic [ADDR_BITS-1:0]   req_guest_addr      = '0;
   logic [ADDR_BITS-1:0]   req_host_rw_addr    = '0;
   logic [ADDR_BITS-1:0]   req_host_fetch_addr = '0;
   logic                   req_access_read     = 1'b0;
   logic                   req_access_write    = 1'b0;
   logic                   req_access_fetch    = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall           = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_remap_valid;
   logic [PAGE_OUT_W-1:0]  rsp_remap_guest_page;
   logic [PAGE_OUT_W-1:0]  rsp_remap_target_page;
   logic                   rsp_remap_allow_rw;
   logic                   rsp_remap_allow_fetch;
   logic                   rsp_flush_translations;

   int mismatch_count;
   int outstanding;
   int results_checked;
   int remaps_seen;
   int rejects_seen;

   int   send_idle_pct = 16;
   int   rsp_stall_pct = 77;
   logic pressure_go   = 1'b0;
   int   hold_cycles   = 0;
   int   sent_by_kind [4] = '{default: 0};

   logic [PAGE_OUT_W-1:0] guest_pool [GUEST_POOL];
   logic [PAGE_OUT_W-1:0] host_pool  [HOST_POOL];

   split_page_remap_table_core #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_BITS   (ADDR_BITS)
   ) DUT (.*);

   remap_table_checker #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_BITS   (ADDR_BITS)
   ) remap_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // result side back-pressure; one long hold-off once pressure_go rises
   always @(posedge clock) begin
      if (pressure_go && hold_cycles < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_cycles++;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   function automatic logic [PAGE_OUT_W-1:0] rand_page();
      return PAGE_OUT_W'({$urandom, $urandom});
   endfunction

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return ADDR_BITS'({$urandom, $urandom});
   endfunction

   function automatic logic [ADDR_BITS-1:0] page_addr(input logic [PAGE_OUT_W-1:0] pg,
                                                      input logic [PAGE_SHIFT-1:0] ofs);
      return {pg, ofs};
   endfunction

   // host page: sometimes a guest page, to provoke clashes
   function automatic logic [PAGE_OUT_W-1:0] pick_host();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2)
         return guest_pool[$urandom_range(0, GUEST_POOL - 1)];
      else if (roll < 6)
         return host_pool[$urandom_range(0, HOST_POOL - 1)];
      return rand_page();
   endfunction

   task automatic send(input req_kind_type kind, input logic [ADDR_BITS-1:0] ga,
                       input logic [ADDR_BITS-1:0] ra, input logic [ADDR_BITS-1:0] fa,
                       input logic rd, input logic wr, input logic fe);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_guest_addr      <= ga;
      req_host_rw_addr    <= ra;
      req_host_fetch_addr <= fa;
      req_access_read     <= rd;
      req_access_write    <= wr;
      req_access_fetch    <= fe;
      do @(posedge clock); while (req_stall);
      sent_by_kind[kind]++;
   endtask

   initial begin
      req_kind_type          kind;
      logic [PAGE_OUT_W-1:0] gpg;
      logic [PAGE_SHIFT-1:0] ofs;
      logic [ADDR_BITS-1:0]  ga;
      logic [ADDR_BITS-1:0]  ra;
      logic [ADDR_BITS-1:0]  fa;
      logic [2:0]            acc;
      bit                    fill_heavy;
      int                    roll;
      int                    map_w;
      int                    unmap_w;

      guest_pool[0] = '0;
      guest_pool[1] = TOP_PAGE;
      for (int i = 2; i < GUEST_POOL; i++)
         guest_pool[i] = rand_page();
      for (int i = 0; i < HOST_POOL; i++)
         host_pool[i] = rand_page();
      fill_heavy = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table lookups
      send(REQ_VIOLATION, page_addr(40'h5, 12'h123), '0, '0, 1'b1, 1'b0, 1'b0);
      send(REQ_UNMAP, page_addr(40'h5, '0), '0, '0, 1'b0, 1'b0, 1'b0);
      // offset on each of the three map addresses
      send(REQ_MAP, page_addr(40'h1, 12'h001), page_addr(40'h2, '0), page_addr(40'h3, '0),
           1'b0, 1'b0, 1'b0);
      send(REQ_MAP, page_addr(40'h1, '0), page_addr(40'h2, 12'h800), page_addr(40'h3, '0),
           1'b0, 1'b0, 1'b0);
      send(REQ_MAP, page_addr(40'h1, '0), page_addr(40'h2, '0), page_addr(40'h3, 12'hfff),
           1'b0, 1'b0, 1'b0);
      // top and bottom guest pages
      send(REQ_MAP, page_addr(TOP_PAGE, '0), page_addr(40'h10, '0), page_addr(40'h20, '0),
           1'b1, 1'b1, 1'b1);
      send(REQ_MAP, '0, page_addr(40'haa_aaaa_aaaa, '0), page_addr(40'h55_5555_5555, '0),
           1'b0, 1'b0, 1'b0);
      // each clash relation
      send(REQ_MAP, page_addr(TOP_PAGE, '0), page_addr(40'h40, '0), page_addr(40'h41, '0),
           1'b0, 1'b0, 1'b0);
      send(REQ_MAP, page_addr(40'h10, '0), page_addr(40'h42, '0), page_addr(40'h43, '0),
           1'b0, 1'b0, 1'b0);
      send(REQ_MAP, page_addr(40'h20, '0), page_addr(40'h44, '0), page_addr(40'h45, '0),
           1'b0, 1'b0, 1'b0);
      send(REQ_MAP, page_addr(40'h30, '0), '0, page_addr(40'h46, '0), 1'b0, 1'b0, 1'b0);
      send(REQ_MAP, page_addr(40'h31, '0), page_addr(40'h47, '0), page_addr(TOP_PAGE, '0),
           1'b0, 1'b0, 1'b0);
      // violations: read, write, fetch, read beats fetch, no access bit
      send(REQ_VIOLATION, page_addr(TOP_PAGE, 12'hfff), '0, '0, 1'b1, 1'b0, 1'b0);
      send(REQ_VIOLATION, page_addr(40'h0, 12'h001), '0, '0, 1'b0, 1'b1, 1'b0);
      send(REQ_VIOLATION, page_addr(TOP_PAGE, '0), '0, '0, 1'b0, 1'b0, 1'b1);
      send(REQ_VIOLATION, page_addr(TOP_PAGE, 12'h7c0), '0, '0, 1'b1, 1'b0, 1'b1);
      send(REQ_VIOLATION, page_addr(40'h0, 12'h020), '0, '0, 1'b0, 1'b0, 1'b0);
      // unmap with offset misses
      send(REQ_UNMAP, page_addr(TOP_PAGE, 12'h010), '0, '0, 1'b0, 1'b0, 1'b0);
      send(REQ_NONE, '1, '1, '1, 1'b1, 1'b1, 1'b1);
      send(REQ_UNMAP, page_addr(TOP_PAGE, '0), '0, '0, 1'b0, 1'b0, 1'b0);
      send(REQ_VIOLATION, page_addr(TOP_PAGE, '0), '0, '0, 1'b0, 1'b1, 1'b0);
      // freed slot gets reused
      send(REQ_MAP, page_addr(40'h50, '0), page_addr(40'h51, '0), page_addr(40'h52, '0),
           1'b0, 1'b0, 1'b0);
      send(REQ_VIOLATION, page_addr(40'h50, 12'h444), '0, '0, 1'b0, 1'b0, 1'b1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 77;
            rsp_stall_pct = 16;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            pressure_go <= 1'b1;
         end
         // alternate filling and draining so the table hits full and empty
         if (n % 64 == 0)
            fill_heavy = $urandom_range(0, 1);
         map_w   = fill_heavy ? 60 : 20;
         unmap_w = fill_heavy ? 12 : 45;
         if ($urandom_range(0, 99) < 6) begin
            kind = req_kind_type'($urandom_range(0, 3));
            ga   = rand_addr();
            ra   = rand_addr();
            fa   = rand_addr();
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < map_w)
               kind = REQ_MAP;
            else if (roll < map_w + unmap_w)
               kind = REQ_UNMAP;
            else if (roll < 97)
               kind = REQ_VIOLATION;
            else
               kind = REQ_NONE;
            gpg = ($urandom_range(0, 9) != 0) ? guest_pool[$urandom_range(0, GUEST_POOL - 1)]
                                              : rand_page();
            ofs = ($urandom_range(0, 9) == 0) ? PAGE_SHIFT'($urandom_range(1, 4095)) : '0;
            if (kind == REQ_VIOLATION)
               ofs = PAGE_SHIFT'($urandom);
            ga = page_addr(gpg, ofs);
            ra = page_addr(pick_host(), ($urandom_range(0, 29) == 0) ?
                           PAGE_SHIFT'($urandom_range(1, 4095)) : '0);
            fa = page_addr(pick_host(), ($urandom_range(0, 29) == 0) ?
                           PAGE_SHIFT'($urandom_range(1, 4095)) : '0);
         end
         acc = 3'($urandom);
         send(kind, ga, ra, fa, acc[2], acc[1], acc[0]);
      end
      req_valid <= 1'b0;

      // let the checker log the last accepted item before polling its count
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (MAX_ENTRIES + 4) @(posedge clock);

      $display("Items: %0d map, %0d unmap, %0d violation, %0d unused code",
               sent_by_kind[REQ_MAP], sent_by_kind[REQ_UNMAP],
               sent_by_kind[REQ_VIOLATION], sent_by_kind[REQ_NONE]);
      $display("Results checked: %0d, remap commands %0d, rejected or missed %0d, bad %0d",
               results_checked, remaps_seen, rejects_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
